>>> rtl/core/tcfm_pkg.sv
// Shared constants, types and command/status structs for the frequency meter core.
package tcfm_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int TIME_BITS = 32;
	localparam int THRESH_BITS = 10;
	localparam int RATE_BITS = 32;
	localparam int FREQ_BITS = 32;
	localparam int ELAPSED_BITS = 32;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_IDX_BITS = 1;

	// Compare width for sample against threshold
	localparam int CMP_BITS = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

	// Restoring divider: one quotient bit per step
	localparam int DIV_STEPS = RATE_BITS;
	localparam int STEP_CNT_BITS = $clog2(DIV_STEPS);
	localparam int REM_BITS = ((TIME_BITS > RATE_BITS) ? TIME_BITS : RATE_BITS) + 1;

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TICK_RATE = 1'b1;

	// Register reset values
	localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET = THRESH_BITS'(512);
	localparam logic [RATE_BITS-1:0] TICK_RATE_RESET = RATE_BITS'(16000000);

	typedef struct packed {
		logic accept;
		logic step;
		logic load_out;
	} tcfm_cmd_t;

	typedef struct packed {
		logic crossing;
		logic out_free;
	} tcfm_sts_t;

endpackage

>>> rtl/core/tcfm_if.sv
// Channel interfaces for sample items and frequency results.
interface tcfm_sample_if;
	import tcfm_pkg::*;

	logic valid;
	logic ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic [TIME_BITS-1:0] timestamp;

	modport source (output valid, output sample, output timestamp, input ready);
	modport sink (input valid, input sample, input timestamp, output ready);
endinterface

interface tcfm_result_if;
	import tcfm_pkg::*;

	logic valid;
	logic ready;
	logic [FREQ_BITS-1:0] frequency_hz;
	logic [ELAPSED_BITS-1:0] elapsed_ticks;
	logic zero_interval;

	modport source (output valid, output frequency_hz, output elapsed_ticks,
		output zero_interval, input ready);
	modport sink (input valid, input frequency_hz, input elapsed_ticks,
		input zero_interval, output ready);
endinterface

>>> rtl/core/tcfm_ctrl.sv
// Controller state machine: sequences accept, divide steps and result load.
module tcfm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tcfm_pkg::tcfm_sts_t sts,
	output tcfm_pkg::tcfm_cmd_t cmd
);
	import tcfm_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam logic [STEP_CNT_BITS-1:0] LAST_STEP = STEP_CNT_BITS'(DIV_STEPS - 1);

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic [STEP_CNT_BITS-1:0] step_cnt_q;

	// Decode commands and next state
	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && sts.crossing) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (step_cnt_q == LAST_STEP) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.step) begin
				step_cnt_q <= step_cnt_q + 1'b1;
			end else begin
				step_cnt_q <= '0;
			end
		end
	end

	a_start_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid && sts.crossing) |=>
		(state_q == ST_DIV && step_cnt_q == '0))
		else $error("crossing did not start divider");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_cnt_q == LAST_STEP) |=> (state_q == ST_DONE))
		else $error("divider did not finish after last step");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result loaded into full output register");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !sts.out_free) |=> (state_q == ST_DONE))
		else $error("result dropped while output stalled");

endmodule

>>> rtl/core/tcfm_datapath.sv
// Datapath: config registers, crossing detect, serial divider and output register.
module tcfm_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [tcfm_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
	input  logic [tcfm_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
	input  logic [tcfm_pkg::SAMPLE_BITS-1:0]     sample,
	input  logic [tcfm_pkg::TIME_BITS-1:0]       timestamp,
	input  tcfm_pkg::tcfm_cmd_t                  cmd,
	output tcfm_pkg::tcfm_sts_t                  sts,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [tcfm_pkg::FREQ_BITS-1:0]       frequency_hz,
	output logic [tcfm_pkg::ELAPSED_BITS-1:0]    elapsed_ticks,
	output logic                                 zero_interval
);
	import tcfm_pkg::*;

	logic [THRESH_BITS-1:0] threshold_q;
	logic [RATE_BITS-1:0] tick_rate_q;
	logic prev_above_q;
	logic [TIME_BITS-1:0] last_capture_q;

	logic [TIME_BITS-1:0] divisor_q;
	logic [ELAPSED_BITS-1:0] elapsed_q;
	logic zero_q;
	logic [RATE_BITS-1:0] quo_q;
	logic [REM_BITS-1:0] rem_q;

	logic out_valid_q;
	logic [FREQ_BITS-1:0] out_freq_q;
	logic [ELAPSED_BITS-1:0] out_elapsed_q;
	logic out_zero_q;

	logic above;
	logic crossing;
	logic [TIME_BITS-1:0] diff;
	logic [REM_BITS-1:0] divisor_ext;
	logic [REM_BITS-1:0] shifted;
	logic [REM_BITS-1:0] trial;
	logic fits;

	// Detect rising crossing and interval
	always_comb begin
		above = CMP_BITS'(sample) >= CMP_BITS'(threshold_q);
		crossing = !prev_above_q && above && (timestamp >= last_capture_q);
		diff = timestamp - last_capture_q;
	end

	// One restoring divide step
	always_comb begin
		divisor_ext = REM_BITS'(divisor_q);
		shifted = {rem_q[REM_BITS-2:0], quo_q[RATE_BITS-1]};
		trial = shifted - divisor_ext;
		fits = shifted >= divisor_ext;
	end

	assign sts.crossing = crossing;
	assign sts.out_free = !out_valid_q || out_ready;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			tick_rate_q <= TICK_RATE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_THRESHOLD: threshold_q <= cfg_wdata[THRESH_BITS-1:0];
				REG_TICK_RATE: tick_rate_q <= cfg_wdata[RATE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Track crossing state and last capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_above_q <= 1'b0;
			last_capture_q <= '0;
		end else if (cmd.accept) begin
			prev_above_q <= above;
			if (crossing) begin
				last_capture_q <= timestamp;
			end
		end
	end

	// Load and iterate divider
	always_ff @(posedge clk) begin
		if (cmd.accept && crossing) begin
			divisor_q <= diff;
			elapsed_q <= ELAPSED_BITS'(diff);
			zero_q <= (diff == '0);
			quo_q <= tick_rate_q;
			rem_q <= '0;
		end else if (cmd.step) begin
			rem_q <= fits ? trial : shifted;
			quo_q <= {quo_q[RATE_BITS-2:0], fits};
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload; saturate on zero interval
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_freq_q <= zero_q ? '1 : FREQ_BITS'(quo_q);
			out_elapsed_q <= elapsed_q;
			out_zero_q <= zero_q;
		end
	end

	assign out_valid = out_valid_q;
	assign frequency_hz = out_freq_q;
	assign elapsed_ticks = out_elapsed_q;
	assign zero_interval = out_zero_q;

endmodule

>>> rtl/core/threshold_crossing_frequency_meter_core.sv
// Result: a rising crossing presents its result after its transfer, its 32 divide steps
// and the output load; the load waits while the output register holds an untaken result.
// Throughput: one sample per cycle between crossings; after a crossing the next sample
// transfers only once the one-bit-per-cycle restoring divider is done and its result loaded.
// Reset: arst_n clears crossing state, last capture and output valid, and sets
// threshold to 512 and tick rate to 16000000.
module threshold_crossing_frequency_meter_core (
	input  logic                               clk,
	input  logic                               arst_n,
	tcfm_sample_if.sink                        sample_ch,
	tcfm_result_if.source                      result_ch,
	input  logic                               cfg_we,
	input  logic [tcfm_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [tcfm_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
	import tcfm_pkg::*;

	tcfm_cmd_t cmd;
	tcfm_sts_t sts;
	logic in_ready;

	// Sequence each transfer
	tcfm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_ch.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	assign sample_ch.ready = in_ready;

	// Compute crossing interval and frequency
	tcfm_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.sample        (sample_ch.sample),
		.timestamp     (sample_ch.timestamp),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (result_ch.valid),
		.out_ready     (result_ch.ready),
		.frequency_hz  (result_ch.frequency_hz),
		.elapsed_ticks (result_ch.elapsed_ticks),
		.zero_interval (result_ch.zero_interval)
	);

endmodule
